[design/mlrq_pkg.sv]
// shared types and codes for the multilevel ready queue
// no dependencies; imported by every module of the block
package mlrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned ID_BITS_DEF     = 8;

  localparam int unsigned TASK_ID_W = 8;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned PRIO_W    = 8;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned STATUS_W  = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [LEVEL_W-1:0] LVL_NONE = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_1    = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_2    = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_3    = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } cmd_t;

endpackage

[design/mlrq_shift_q.sv]
// one ready queue kept in order as a row of shift cells
// a new entry goes in front of the first cell whose key is larger; uses mlrq_pkg
module mlrq_shift_q #(
  parameter int unsigned DEPTH    = 16,
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned ID_W     = 8,
  parameter int unsigned CNT_W    = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmp_i,
  input  logic                ins_i,
  input  logic                pop_i,
  input  logic [KEY_BITS-1:0] new_key_i,
  input  logic [ID_W-1:0]     new_id_i,
  output logic                full_o,
  output logic                empty_o,
  output logic [ID_W-1:0]     front_id_o
);
  import mlrq_pkg::*;

  logic [KEY_BITS-1:0] key_q [DEPTH];
  logic [ID_W-1:0]     id_q  [DEPTH];
  logic [CNT_W-1:0]    count_q, count_d;
  logic [DEPTH-1:0]    before_q, before_d;
  logic [DEPTH-1:0]    in_use, goes_ahead, take_new, shift_in;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      in_use[i]     = CNT_W'(i) < count_q;
      before_d[i]   = in_use[i] && (new_key_i < key_q[i]);
      // new entry lands at or ahead of this cell
      goes_ahead[i] = before_q[i] || !in_use[i];
    end
    take_new[0] = goes_ahead[0];
    shift_in[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) begin
      take_new[i] = goes_ahead[i] && !goes_ahead[i-1];
      shift_in[i] = before_q[i-1];
    end
  end

  always_comb begin
    count_d = count_q;
    if (pop_i) begin
      count_d = count_q - CNT_W'(1);
    end else if (ins_i) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_i) begin
      before_q <= before_d;
    end
    if (pop_i) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        key_q[i] <= key_q[i+1];
        id_q[i]  <= id_q[i+1];
      end
    end else if (ins_i) begin
      if (take_new[0]) begin
        key_q[0] <= new_key_i;
        id_q[0]  <= new_id_i;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (take_new[i]) begin
          key_q[i] <= new_key_i;
          id_q[i]  <= new_id_i;
        end else if (shift_in[i]) begin
          key_q[i] <= key_q[i-1];
          id_q[i]  <= id_q[i-1];
        end
      end
    end
  end

  assign full_o     = count_q == CNT_W'(DEPTH);
  assign empty_o    = count_q == '0;
  assign front_id_o = id_q[0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_no_ins_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ins_i && pop_i))
    else $error("insert and pop in one cycle");
  a_ins_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_i |-> !full_o)
    else $error("insert into full queue");
  a_pop_some: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

[design/mlrq_datapath.sv]
// datapath: item register, the three level queues and the result register
// depends on mlrq_pkg and mlrq_shift_q
module mlrq_datapath #(
  parameter int unsigned QUEUE_DEPTH = mlrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = mlrq_pkg::ID_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mlrq_pkg::cmd_t                  cmd_i,
  input  logic                            kind_i,
  input  logic [mlrq_pkg::TASK_ID_W-1:0]  task_id_i,
  input  logic [mlrq_pkg::LEVEL_W-1:0]    task_level_i,
  input  logic [mlrq_pkg::PRIO_W-1:0]     task_priority_i,
  input  logic [mlrq_pkg::TIME_W-1:0]     remaining_time_i,
  output logic [mlrq_pkg::STATUS_W-1:0]   status_o,
  output logic [mlrq_pkg::TASK_ID_W-1:0]  out_task_id_o,
  output logic [mlrq_pkg::LEVEL_W-1:0]    out_level_o
);
  import mlrq_pkg::*;

  // stored id bits: the port carries eight, the slice keeps the low ID_BITS of them, at most eight
  localparam int unsigned ID_W  = (ID_BITS < TASK_ID_W) ? ID_BITS : TASK_ID_W;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned K2_W  = PRIO_W + ID_W;

  logic                kind_q;
  logic [ID_W-1:0]     id_q;
  logic [LEVEL_W-1:0]  level_q;
  logic [PRIO_W-1:0]   prio_q;
  logic [TIME_W-1:0]   time_q;

  logic [STATUS_W-1:0]  status_q, status_d;
  logic [TASK_ID_W-1:0] oid_q, oid_d;
  logic [LEVEL_W-1:0]   olev_q, olev_d;

  logic [2:0]      ins, pop, full, empty;
  logic [ID_W-1:0] front1, front2, front3;
  logic [K2_W-1:0] key2;

  // higher priority then lower id first, as one ascending key
  assign key2 = {~prio_q, id_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_i;
      id_q    <= task_id_i[ID_W-1:0];
      level_q <= task_level_i;
      prio_q  <= task_priority_i;
      time_q  <= remaining_time_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      oid_q    <= oid_d;
      olev_q   <= olev_d;
    end
  end

  always_comb begin
    ins      = '0;
    pop      = '0;
    status_d = STATUS_EMPTY;
    oid_d    = '0;
    olev_d   = LVL_NONE;
    if (kind_q == KIND_ENQ) begin
      status_d = STATUS_ENQUEUED;
      case (level_q)
        LVL_1: begin
          if (full[0]) status_d = STATUS_FULL;
          else         ins[0]   = cmd_i.commit;
        end
        LVL_2: begin
          if (full[1]) status_d = STATUS_FULL;
          else         ins[1]   = cmd_i.commit;
        end
        default: begin
          if (full[2]) status_d = STATUS_FULL;
          else         ins[2]   = cmd_i.commit;
        end
      endcase
    end else if (!empty[0]) begin
      pop[0]   = cmd_i.commit;
      status_d = STATUS_DEQUEUED;
      oid_d    = TASK_ID_W'(front1);
      olev_d   = LVL_1;
    end else if (!empty[1]) begin
      pop[1]   = cmd_i.commit;
      status_d = STATUS_DEQUEUED;
      oid_d    = TASK_ID_W'(front2);
      olev_d   = LVL_2;
    end else if (!empty[2]) begin
      pop[2]   = cmd_i.commit;
      status_d = STATUS_DEQUEUED;
      oid_d    = TASK_ID_W'(front3);
      olev_d   = LVL_3;
    end
  end

  mlrq_shift_q #(
    .DEPTH(QUEUE_DEPTH), .KEY_BITS(TIME_W), .ID_W(ID_W), .CNT_W(CNT_W)
  ) u_level1 (
    .clk_i, .rst_ni, .cmp_i(cmd_i.compare), .ins_i(ins[0]), .pop_i(pop[0]),
    .new_key_i(time_q), .new_id_i(id_q),
    .full_o(full[0]), .empty_o(empty[0]), .front_id_o(front1)
  );

  mlrq_shift_q #(
    .DEPTH(QUEUE_DEPTH), .KEY_BITS(K2_W), .ID_W(ID_W), .CNT_W(CNT_W)
  ) u_level2 (
    .clk_i, .rst_ni, .cmp_i(cmd_i.compare), .ins_i(ins[1]), .pop_i(pop[1]),
    .new_key_i(key2), .new_id_i(id_q),
    .full_o(full[1]), .empty_o(empty[1]), .front_id_o(front2)
  );

  // fifo level: a constant key never sorts ahead, so entries go to the tail
  mlrq_shift_q #(
    .DEPTH(QUEUE_DEPTH), .KEY_BITS(1), .ID_W(ID_W), .CNT_W(CNT_W)
  ) u_level3 (
    .clk_i, .rst_ni, .cmp_i(cmd_i.compare), .ins_i(ins[2]), .pop_i(pop[2]),
    .new_key_i(1'b0), .new_id_i(id_q),
    .full_o(full[2]), .empty_o(empty[2]), .front_id_o(front3)
  );

  assign status_o      = status_q;
  assign out_task_id_o = oid_q;
  assign out_level_o   = olev_q;

  a_one_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({ins, pop}) <= 1)
    else $error("more than one queue changed for one beat");
  a_deq_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit && (status_d == STATUS_DEQUEUED) |-> olev_d != LVL_NONE)
    else $error("dequeue without source level");
  a_order_l1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop[0] |-> kind_q == KIND_DEQ)
    else $error("level 1 popped on an enqueue beat");

endmodule

[design/mlrq_ctrl.sv]
// controller: sequences load, compare and commit for one beat, then strobes the result
// depends on mlrq_pkg
module mlrq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  output logic           done_o,
  output mlrq_pkg::cmd_t cmd_o
);
  import mlrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_COMMIT,
    S_RESP
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_CMP;
      S_CMP:    state_d = S_COMMIT;
      S_COMMIT: state_d = S_RESP;
      S_RESP:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
    busy_d = state_d != S_IDLE;
    done_d = state_d == S_RESP;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o.load    = start_i && !busy_q;
  assign cmd_o.compare = state_q == S_CMP;
  assign cmd_o.commit  = state_q == S_COMMIT;
  assign busy_o        = busy_q;
  assign done_o        = done_q;

  a_done_after_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(cmd_o.commit))
    else $error("result strobe without commit");
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy_o)
    else $error("accepted beat did not raise busy");

endmodule

[design/multilevel_ready_queue_top.sv]
// multilevel ready queue: three task queues behind a start/busy command port
// depends on mlrq_pkg, mlrq_ctrl and mlrq_datapath
//
// usage
//   a beat is taken at a rising edge with start high and busy low.
//   kind_i 0 enqueues task_id_i: level 1 sorted by remaining_time_i (ties in
//   arrival order), level 2 by task_priority_i high first then lower id,
//   any other level into the level 3 fifo. kind_i 1 dequeues the front task
//   of the first non-empty level.
//   every beat gives exactly one result, held on status_o, out_task_id_o
//   and out_level_o for the single cycle that done_o is high; the receiver
//   cannot hold it off.
//   sequence: an accepted beat runs a compare step across all cells of the
//   queues, a commit step that shifts the cells, then the result step with
//   done_o high; busy falls at the edge that ends the result step, and the
//   controller is back in idle before the next beat can be taken.
//   reset clears the three fill counts and the controller; queue cells
//   are not cleared and are only read below their count.
module multilevel_ready_queue_top #(
  parameter int unsigned QUEUE_DEPTH = mlrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = mlrq_pkg::ID_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  output logic                            done_o,
  input  logic                            kind_i,
  input  logic [mlrq_pkg::TASK_ID_W-1:0]  task_id_i,
  input  logic [mlrq_pkg::LEVEL_W-1:0]    task_level_i,
  input  logic [mlrq_pkg::PRIO_W-1:0]     task_priority_i,
  input  logic [mlrq_pkg::TIME_W-1:0]     remaining_time_i,
  output logic [mlrq_pkg::STATUS_W-1:0]   status_o,
  output logic [mlrq_pkg::TASK_ID_W-1:0]  out_task_id_o,
  output logic [mlrq_pkg::LEVEL_W-1:0]    out_level_o
);
  import mlrq_pkg::*;

  cmd_t cmd;

  mlrq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start),
    .busy_o(busy),
    .done_o,
    .cmd_o(cmd)
  );

  mlrq_datapath #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)
  ) u_datapath (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .kind_i, .task_id_i, .task_level_i, .task_priority_i, .remaining_time_i,
    .status_o, .out_task_id_o, .out_level_o
  );

endmodule
